// ===== hdl/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// shared types, field widths, request codes and parameter defaults of the
// scaler, alarm and timing unit
// ----------------------------------------------------------------------------
package sat_pkg;

  // parameter defaults
  localparam int KEY_STAGE_BIT_DEF   = 8;
  localparam int FAST_STAGE_BIT_DEF  = 9;
  localparam int SLOW_STAGE_BIT_DEF  = 13;
  localparam int KEY_QUEUE_DEPTH_DEF = 8;

  // field widths
  localparam int REQ_W  = 3;
  localparam int CHAN_W = 6;
  localparam int DATA_W = 15;

  // request codes, six and seven are unused
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 3'd0,
    REQ_RUPT_START = 3'd1,
    REQ_RUPT_END   = 3'd2,
    REQ_TC_START   = 3'd3,
    REQ_TC_END     = 3'd4,
    REQ_KEY        = 3'd5
  } req_type_t;

  // channels that raise a key interrupt
  localparam logic [CHAN_W-1:0] KEY_CHAN_LO = 6'd4;
  localparam logic [CHAN_W-1:0] KEY_CHAN_HI = 6'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic              in_interrupt;
    logic [CHAN_W-1:0] key_channel;
    logic [DATA_W-1:0] key_data;
  } sat_item_t;

  typedef struct packed {
    logic              gojam;
    logic              alarm_rupt_long;
    logic              alarm_tc_only;
    logic              alarm_no_tc;
    logic              alarm_no_rupt;
    logic              time13_up;
    logic              time4_up;
    logic              keyrupt;
    logic              key_register;
    logic [DATA_W-1:0] key_value;
    logic              queue_dropped;
  } sat_result_t;

endpackage

// ===== hdl/sat_if.sv =====
// ----------------------------------------------------------------------------
// sat_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface sat_item_if import sat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic              in_interrupt;
  logic [CHAN_W-1:0] key_channel;
  logic [DATA_W-1:0] key_data;

  modport source (output valid, req_type, in_interrupt, key_channel, key_data,
                  input ready);
  modport sink   (input valid, req_type, in_interrupt, key_channel, key_data,
                  output ready);
endinterface

interface sat_result_if import sat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              gojam;
  logic              alarm_rupt_long;
  logic              alarm_tc_only;
  logic              alarm_no_tc;
  logic              alarm_no_rupt;
  logic              time13_up;
  logic              time4_up;
  logic              keyrupt;
  logic              key_register;
  logic [DATA_W-1:0] key_value;
  logic              queue_dropped;

  modport source (output valid, gojam, alarm_rupt_long, alarm_tc_only, alarm_no_tc,
                  alarm_no_rupt, time13_up, time4_up, keyrupt, key_register,
                  key_value, queue_dropped,
                  input ready);
  modport sink   (input valid, gojam, alarm_rupt_long, alarm_tc_only, alarm_no_tc,
                  alarm_no_rupt, time13_up, time4_up, keyrupt, key_register,
                  key_value, queue_dropped,
                  output ready);
endinterface

// ===== hdl/sat_in_stage.sv =====
// ----------------------------------------------------------------------------
// sat_in_stage
// input register, holds one accepted item until the core takes it
// ----------------------------------------------------------------------------
module sat_in_stage import sat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sat_item_if.sink  item,
  input  logic      take,
  output logic      held_valid,
  output sat_item_t held_item
);

  assign item.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item.req_type     <= item.req_type;
      held_item.in_interrupt <= item.in_interrupt;
      held_item.key_channel  <= item.key_channel;
      held_item.key_data     <= item.key_data;
    end
  end

endmodule

// ===== hdl/sat_core.sv =====
// ----------------------------------------------------------------------------
// sat_core
// divider, watchdog flags, key queue and the result logic for one item
// ----------------------------------------------------------------------------
module sat_core import sat_pkg::*; #(
  parameter int KEY_STAGE_BIT   = KEY_STAGE_BIT_DEF,
  parameter int FAST_STAGE_BIT  = FAST_STAGE_BIT_DEF,
  parameter int SLOW_STAGE_BIT  = SLOW_STAGE_BIT_DEF,
  parameter int KEY_QUEUE_DEPTH = KEY_QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  sat_item_t   cur_item,
  output sat_result_t res
);

  localparam int DIV_W   = SLOW_STAGE_BIT + 1;
  localparam int CNT_W   = $clog2(KEY_QUEUE_DEPTH + 1);
  localparam int PTR_W   = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
  localparam int ENTRY_W = CHAN_W + DATA_W;

  // stages above the divider never toggle
  localparam bit KEY_IN   = (KEY_STAGE_BIT <= SLOW_STAGE_BIT);
  localparam bit FAST_IN  = (FAST_STAGE_BIT <= SLOW_STAGE_BIT);
  localparam int KEY_IDX  = KEY_IN ? KEY_STAGE_BIT : 0;
  localparam int FAST_IDX = FAST_IN ? FAST_STAGE_BIT : 0;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KEY_QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(KEY_QUEUE_DEPTH - 1);

  logic [DIV_W-1:0]   divider_count, divider_count_next, div_cur;
  logic               rupt_end_seen, rupt_end_seen_next;
  logic               tc_end_seen, tc_end_seen_next;
  logic               tc_start_seen, tc_start_seen_next;
  logic               rupt_start_seen, rupt_start_seen_next;
  logic [CNT_W-1:0]   key_queue_count, key_queue_count_next;
  logic [PTR_W-1:0]   head, head_next, tail, tail_next;
  logic [ENTRY_W-1:0] key_queue [KEY_QUEUE_DEPTH];
  logic [ENTRY_W-1:0] head_entry;
  logic [ENTRY_W-1:0] wr_entry;
  logic [CHAN_W-1:0]  head_chan, chan_ofs;
  logic [DATA_W-1:0]  head_data;
  logic               pop, push;
  logic               key_rise, fast_rise, fast_fall, slow_rise, slow_fall;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign div_cur   = divider_count + 1'b1;
  assign key_rise  = KEY_IN && div_cur[KEY_IDX] && !divider_count[KEY_IDX];
  assign fast_rise = FAST_IN && div_cur[FAST_IDX] && !divider_count[FAST_IDX];
  assign fast_fall = FAST_IN && !div_cur[FAST_IDX] && divider_count[FAST_IDX];
  assign slow_rise = div_cur[SLOW_STAGE_BIT] && !divider_count[SLOW_STAGE_BIT];
  assign slow_fall = !div_cur[SLOW_STAGE_BIT] && divider_count[SLOW_STAGE_BIT];

  assign head_chan = head_entry[ENTRY_W-1:DATA_W];
  assign head_data = head_entry[DATA_W-1:0];
  assign chan_ofs  = head_chan - KEY_CHAN_LO;
  assign wr_entry  = {cur_item.key_channel, cur_item.key_data};

  always_comb begin
    divider_count_next   = divider_count;
    rupt_end_seen_next   = rupt_end_seen;
    tc_end_seen_next     = tc_end_seen;
    tc_start_seen_next   = tc_start_seen;
    rupt_start_seen_next = rupt_start_seen;
    pop                  = 1'b0;
    push                 = 1'b0;
    res                  = '0;
    if (step) begin
      case (req_type_t'(cur_item.req_type))
        REQ_TICK: begin
          divider_count_next = div_cur;
          if (key_rise && key_queue_count != '0) begin
            pop = 1'b1;
            if ((head_chan == KEY_CHAN_LO || head_chan == KEY_CHAN_HI) &&
                head_data != '0) begin
              res.keyrupt      = 1'b1;
              res.key_register = chan_ofs[0];
              res.key_value    = head_data;
            end
          end
          if (fast_fall) begin
            res.alarm_rupt_long = !rupt_end_seen;
            res.alarm_tc_only   = !tc_end_seen;
            res.alarm_no_tc     = !tc_start_seen;
            res.time13_up       = 1'b1;
            if (cur_item.in_interrupt) begin
              rupt_end_seen_next = 1'b0;
            end
            tc_start_seen_next = 1'b0;
            tc_end_seen_next   = 1'b0;
          end
          if (fast_rise) begin
            res.time4_up = 1'b1;
          end
          if (slow_fall) begin
            rupt_start_seen_next = 1'b0;
          end
          if (slow_rise) begin
            res.alarm_no_rupt = !rupt_start_seen;
          end
          res.gojam = res.alarm_rupt_long | res.alarm_tc_only |
                      res.alarm_no_tc | res.alarm_no_rupt;
        end
        REQ_RUPT_START: rupt_start_seen_next = 1'b1;
        REQ_RUPT_END:   rupt_end_seen_next   = 1'b1;
        REQ_TC_START:   tc_start_seen_next   = 1'b1;
        REQ_TC_END:     tc_end_seen_next     = 1'b1;
        REQ_KEY: begin
          if (key_queue_count == CNT_FULL) begin
            res.queue_dropped = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign head_next = pop ? ptr_inc(head) : head;
  assign tail_next = push ? ptr_inc(tail) : tail;

  always_comb begin
    key_queue_count_next = key_queue_count;
    if (push) begin
      key_queue_count_next = key_queue_count + 1'b1;
    end else if (pop) begin
      key_queue_count_next = key_queue_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count   <= '0;
      rupt_end_seen   <= 1'b0;
      tc_end_seen     <= 1'b0;
      tc_start_seen   <= 1'b0;
      rupt_start_seen <= 1'b0;
      key_queue_count <= '0;
      head            <= '0;
      tail            <= '0;
    end else begin
      divider_count   <= divider_count_next;
      rupt_end_seen   <= rupt_end_seen_next;
      tc_end_seen     <= tc_end_seen_next;
      tc_start_seen   <= tc_start_seen_next;
      rupt_start_seen <= rupt_start_seen_next;
      key_queue_count <= key_queue_count_next;
      head            <= head_next;
      tail            <= tail_next;
    end
  end

  // queue memory, head entry kept in a read register, bypass on a push into empty
  always_ff @(posedge clk) begin
    if (push) begin
      key_queue[tail] <= wr_entry;
    end
    if (push && tail == head_next) begin
      head_entry <= wr_entry;
    end else begin
      head_entry <= key_queue[head_next];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    key_queue_count <= CNT_FULL)
    else $error("key queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    key_queue_count == '0 |-> head == tail)
    else $error("empty queue with head and tail apart");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop |=> key_queue_count == $past(key_queue_count) - 1'b1)
    else $error("pop did not decrement count");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |=> key_queue_count == $past(key_queue_count) + 1'b1)
    else $error("push did not increment count");
`endif

endmodule

// ===== hdl/sat_out_stage.sv =====
// ----------------------------------------------------------------------------
// sat_out_stage
// result register, drives the result channel
// ----------------------------------------------------------------------------
module sat_out_stage import sat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  sat_result_t res,
  output logic        free,
  sat_result_if.source result
);

  sat_result_t held;
  logic        held_valid;

  assign free = !held_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (result.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid           = held_valid;
  assign result.gojam           = held.gojam;
  assign result.alarm_rupt_long = held.alarm_rupt_long;
  assign result.alarm_tc_only   = held.alarm_tc_only;
  assign result.alarm_no_tc     = held.alarm_no_tc;
  assign result.alarm_no_rupt   = held.alarm_no_rupt;
  assign result.time13_up       = held.time13_up;
  assign result.time4_up        = held.time4_up;
  assign result.keyrupt         = held.keyrupt;
  assign result.key_register    = held.key_register;
  assign result.key_value       = held.key_value;
  assign result.queue_dropped   = held.queue_dropped;

endmodule

// ===== hdl/scaler_alarm_timing_unit_core.sv =====
// ----------------------------------------------------------------------------
// scaler_alarm_timing_unit_core
// scaler with watchdog alarms, timer increment requests and a key update queue
// ----------------------------------------------------------------------------
//  channel  | modport | transaction
//  ---------+---------+------------------------------------------------------
//  item     | sink    | tick, interrupt/tc start or end event, or key update
//  result   | source  | alarms, gojam, timer requests, key interrupt, drop flag
//
//  one transaction per cycle sustained on both channels while result.ready is high;
//  each item gives one result through the input register, then the result register
//  the whole step is divider increment, edge detection and flag/queue update
//  between the two registers; the queue head is kept in a registered read port
//  rst is synchronous: clears divider, watchdog flags, queue pointers and count
//  a stalled result holds in the result register while one more item waits in
//  the input register; item.ready drops only when both are occupied
// ----------------------------------------------------------------------------
module scaler_alarm_timing_unit_core import sat_pkg::*; #(
  parameter int KEY_STAGE_BIT   = KEY_STAGE_BIT_DEF,
  parameter int FAST_STAGE_BIT  = FAST_STAGE_BIT_DEF,
  parameter int SLOW_STAGE_BIT  = SLOW_STAGE_BIT_DEF,
  parameter int KEY_QUEUE_DEPTH = KEY_QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  sat_item_if.sink     item,
  sat_result_if.source result
);

  logic        held_valid;
  sat_item_t   held_item;
  logic        out_free;
  logic        step;
  sat_result_t res;

  // the held item is processed in the cycle the result register can take it
  assign step = held_valid && out_free;

  sat_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // divider, watchdogs and key queue
  sat_core #(
    .KEY_STAGE_BIT   (KEY_STAGE_BIT),
    .FAST_STAGE_BIT  (FAST_STAGE_BIT),
    .SLOW_STAGE_BIT  (SLOW_STAGE_BIT),
    .KEY_QUEUE_DEPTH (KEY_QUEUE_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cur_item (held_item),
    .res      (res)
  );

  sat_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .res    (res),
    .free   (out_free),
    .result (result)
  );

endmodule

// ===== dv/scaler_alarm_timing_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// scaler_alarm_timing_unit_core_tb
// self-checking bench for the scaler, alarm and timing unit: items go in over
// a valid/ready channel with random gaps, a local scaler model predicts every
// result, and each result transaction is checked field by field in order
// ----------------------------------------------------------------------------
module scaler_alarm_timing_unit_core_tb import sat_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int DIV_W        = SLOW_STAGE_BIT_DEF + 1;
  localparam int KEY_RISE_AT  = 1 << KEY_STAGE_BIT_DEF;
  localparam int FAST_RISE_AT = 1 << FAST_STAGE_BIT_DEF;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 35;

  // request codes that the block ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sat_item_if   item_ch ();
  sat_result_if result_ch ();

  scaler_alarm_timing_unit_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // local copy of the scaler state
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0]  scaler_div      = '0;
  logic              seen_rupt_end   = 1'b0;
  logic              seen_tc_end     = 1'b0;
  logic              seen_tc_start   = 1'b0;
  logic              seen_rupt_start = 1'b0;
  logic [CHAN_W-1:0] keyq_chan [KEY_QUEUE_DEPTH_DEF];
  logic [DATA_W-1:0] keyq_data [KEY_QUEUE_DEPTH_DEF];
  int                keyq_count = 0;
  int                keyq_head  = 0;

  // outputs predicted for accepted items, oldest first
  sat_result_t awaited_outputs [$];

  // stimulus controls, written by the test tasks
  int tx_idle_pct  = IDLE_PCT;
  int rx_idle_pct  = IDLE_PCT;
  int rx_hold_left = 0;

  // bookkeeping
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned keyrupts_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned time4_seen = 0;
  int          stall_cycles = 0;

  // one step of the scaler: advances the local state, returns the outputs
  function automatic sat_result_t advance_scaler(input sat_item_t it);
    sat_result_t       r;
    logic [DIV_W-1:0]  nxt;
    logic [DIV_W-1:0]  chg;
    logic [CHAN_W-1:0] chan;
    logic [CHAN_W-1:0] reg_ofs;
    logic [DATA_W-1:0] data;
    int                slot;
    r = '0;
    case (it.req_type)
      REQ_TICK: begin
        nxt = scaler_div + 1'b1;
        chg = scaler_div ^ nxt;
        scaler_div = nxt;
        // key stage rising edge pops the head entry
        if (chg[KEY_STAGE_BIT_DEF] && nxt[KEY_STAGE_BIT_DEF] && keyq_count > 0) begin
          chan = keyq_chan[keyq_head];
          data = keyq_data[keyq_head];
          // other channels and zero data are popped silently
          if ((chan == KEY_CHAN_LO || chan == KEY_CHAN_HI) && data != '0) begin
            reg_ofs = chan - KEY_CHAN_LO;
            r.keyrupt = 1'b1;
            r.key_register = reg_ofs[0];
            r.key_value = data;
          end
          keyq_head = (keyq_head + 1) % KEY_QUEUE_DEPTH_DEF;
          keyq_count--;
        end
        // fast stage falling edge: watchdog check, timer request, re-arm
        if (chg[FAST_STAGE_BIT_DEF] && !nxt[FAST_STAGE_BIT_DEF]) begin
          r.alarm_rupt_long = !seen_rupt_end;
          r.alarm_tc_only = !seen_tc_end;
          r.alarm_no_tc = !seen_tc_start;
          r.time13_up = 1'b1;
          // the interrupt-end flag only clears while inside an interrupt
          if (it.in_interrupt) seen_rupt_end = 1'b0;
          seen_tc_start = 1'b0;
          seen_tc_end = 1'b0;
        end
        if (chg[FAST_STAGE_BIT_DEF] && nxt[FAST_STAGE_BIT_DEF]) r.time4_up = 1'b1;
        if (chg[SLOW_STAGE_BIT_DEF] && !nxt[SLOW_STAGE_BIT_DEF]) seen_rupt_start = 1'b0;
        if (chg[SLOW_STAGE_BIT_DEF] && nxt[SLOW_STAGE_BIT_DEF])
          r.alarm_no_rupt = !seen_rupt_start;
        r.gojam = r.alarm_rupt_long | r.alarm_tc_only | r.alarm_no_tc | r.alarm_no_rupt;
      end
      REQ_RUPT_START: seen_rupt_start = 1'b1;
      REQ_RUPT_END:   seen_rupt_end = 1'b1;
      REQ_TC_START:   seen_tc_start = 1'b1;
      REQ_TC_END:     seen_tc_end = 1'b1;
      REQ_KEY: begin
        if (keyq_count >= KEY_QUEUE_DEPTH_DEF) begin
          r.queue_dropped = 1'b1;
        end else begin
          slot = (keyq_head + keyq_count) % KEY_QUEUE_DEPTH_DEF;
          keyq_chan[slot] = it.key_channel;
          keyq_data[slot] = it.key_data;
          keyq_count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string differing_fields(input sat_result_t w, input sat_result_t g);
    string s;
    s = "";
    if (w.gojam !== g.gojam) s = {s, " gojam"};
    if (w.alarm_rupt_long !== g.alarm_rupt_long) s = {s, " alarm_rupt_long"};
    if (w.alarm_tc_only !== g.alarm_tc_only) s = {s, " alarm_tc_only"};
    if (w.alarm_no_tc !== g.alarm_no_tc) s = {s, " alarm_no_tc"};
    if (w.alarm_no_rupt !== g.alarm_no_rupt) s = {s, " alarm_no_rupt"};
    if (w.time13_up !== g.time13_up) s = {s, " time13_up"};
    if (w.time4_up !== g.time4_up) s = {s, " time4_up"};
    if (w.keyrupt !== g.keyrupt) s = {s, " keyrupt"};
    if (w.key_register !== g.key_register) s = {s, " key_register"};
    if (w.key_value !== g.key_value) s = {s, " key_value"};
    if (w.queue_dropped !== g.queue_dropped) s = {s, " queue_dropped"};
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // item side: every accepted transaction feeds the model
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_monitor
    sat_item_t seen;
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen.req_type = item_ch.req_type;
      seen.in_interrupt = item_ch.in_interrupt;
      seen.key_channel = item_ch.key_channel;
      seen.key_data = item_ch.key_data;
      awaited_outputs.push_back(advance_scaler(seen));
      items_accepted++;
    end
  end

  // --------------------------------------------------------------------------
  // result side: compare each result transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    sat_result_t got;
    sat_result_t want;
    string       bad;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.gojam = result_ch.gojam;
      got.alarm_rupt_long = result_ch.alarm_rupt_long;
      got.alarm_tc_only = result_ch.alarm_tc_only;
      got.alarm_no_tc = result_ch.alarm_no_tc;
      got.alarm_no_rupt = result_ch.alarm_no_rupt;
      got.time13_up = result_ch.time13_up;
      got.time4_up = result_ch.time4_up;
      got.keyrupt = result_ch.keyrupt;
      got.key_register = result_ch.key_register;
      got.key_value = result_ch.key_value;
      got.queue_dropped = result_ch.queue_dropped;
      if (awaited_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: result %h arrived with nothing awaited", $realtime, got);
      end else begin
        want = awaited_outputs.pop_front();
        bad = differing_fields(want, got);
        if (bad != "") begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%t: result %0d mismatch in%s: expected %h, actual %h",
                     $realtime, results_checked, bad, want, got);
        end
        if (want.keyrupt) keyrupts_seen++;
        if (want.queue_dropped) drops_seen++;
        if (want.time4_up) time4_seen++;
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // result ready: random idling, or a counted hold-off when a test asks
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      result_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // random content around a given request code, key channels lean to 4 and 5
  function automatic sat_item_t rand_fields(input logic [REQ_W-1:0] kind);
    sat_item_t it;
    it.req_type = kind;
    it.in_interrupt = 1'($urandom_range(1));
    if ($urandom_range(99) < 60)
      it.key_channel = ($urandom_range(1) == 0) ? KEY_CHAN_LO : KEY_CHAN_HI;
    else
      it.key_channel = CHAN_W'($urandom_range(63));
    it.key_data = ($urandom_range(9) == 0) ? '0 : DATA_W'($urandom_range(32767));
    return it;
  endfunction

  function automatic logic [REQ_W-1:0] rand_event();
    case ($urandom_range(3))
      0:       return REQ_RUPT_START;
      1:       return REQ_RUPT_END;
      2:       return REQ_TC_START;
      default: return REQ_TC_END;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] rand_kind(input int tick_pct, input int key_pct);
    int r;
    r = $urandom_range(99);
    if (r < tick_pct) return REQ_TICK;
    if (r < tick_pct + key_pct) return REQ_KEY;
    if (r < tick_pct + key_pct + 2) return ($urandom_range(1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
    return rand_event();
  endfunction

  function automatic sat_item_t key_item(input logic [CHAN_W-1:0] chan,
                                         input logic [DATA_W-1:0] data);
    sat_item_t it;
    it = rand_fields(REQ_KEY);
    it.key_channel = chan;
    it.key_data = data;
    return it;
  endfunction

  // offer one item, with a random gap first, and hold it until accepted
  task automatic send_item(input sat_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.req_type <= it.req_type;
    item_ch.in_interrupt <= it.in_interrupt;
    item_ch.key_channel <= it.key_channel;
    item_ch.key_data <= it.key_data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait for every awaited result, then the pipeline latency
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // ticks only, past the first key stage rising edge: pops the queue head
  task automatic test_key_stage_pop();
    repeat (KEY_RISE_AT + 8) send_item(rand_fields(REQ_TICK));
    wait_drained();
  endtask

  // field extremes, each event, ignored codes, queue corner cases
  task automatic test_directed();
    sat_item_t it;
    it = '0;
    it.req_type = REQ_TICK;
    send_item(it);
    it.in_interrupt = 1'b1;
    it.key_channel = '1;
    it.key_data = '1;
    send_item(it);
    send_item(rand_fields(REQ_RUPT_START));
    send_item(rand_fields(REQ_RUPT_END));
    send_item(rand_fields(REQ_TC_START));
    send_item(rand_fields(REQ_TC_END));
    // ignored codes, one with every field at its top value
    send_item(rand_fields(REQ_SPARE_A));
    it.req_type = REQ_SPARE_B;
    send_item(it);
    // fill the queue: zero data and foreign channels among the entries
    send_item(key_item(KEY_CHAN_LO, '1));
    send_item(key_item(KEY_CHAN_HI, '0));
    send_item(key_item('1, DATA_W'($urandom_range(32767))));
    send_item(key_item('0, '0));
    send_item(key_item(KEY_CHAN_HI, DATA_W'(1)));
    send_item(key_item(KEY_CHAN_LO, DATA_W'($urandom_range(32767))));
    send_item(key_item(KEY_CHAN_HI, DATA_W'($urandom_range(32767))));
    send_item(key_item(CHAN_W'(3), DATA_W'($urandom_range(32767))));
    // queue now full, these two are dropped
    send_item(key_item(KEY_CHAN_HI, '1));
    send_item(key_item('1, '1));
    wait_drained();
  endtask

  // mixed random traffic with a stretch of no idling in the middle
  task automatic test_random_mix();
    repeat (100) send_item(rand_fields(rand_kind(70, 10)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (60) send_item(rand_fields(rand_kind(70, 10)));
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    repeat (100) send_item(rand_fields(rand_kind(70, 10)));
    wait_drained();
  endtask

  // result side held off while items keep coming, so the input stalls
  task automatic test_backpressure();
    rx_hold_left = HOLD_CYCLES;
    tx_idle_pct = 0;
    repeat (40) send_item(rand_fields(rand_kind(60, 20)));
    tx_idle_pct = IDLE_PCT;
    wait_drained();
  endtask

  // tick-heavy run until the divider is past the fast stage rising edge
  task automatic test_divider_sweep();
    int               r;
    logic [REQ_W-1:0] kind;
    while (scaler_div < DIV_W'(FAST_RISE_AT + 32)) begin
      r = $urandom_range(999);
      if (r < 4) kind = REQ_KEY;
      else if (r < 10) kind = rand_event();
      else if (r == 10) kind = REQ_SPARE_A;
      else kind = REQ_TICK;
      send_item(rand_fields(kind));
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    item_ch.valid = 1'b0;
    item_ch.req_type = REQ_TICK;
    item_ch.in_interrupt = 1'b0;
    item_ch.key_channel = '0;
    item_ch.key_data = '0;
    result_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_key_stage_pop();
    test_random_mix();
    test_backpressure();
    test_divider_sweep();

    $display("items %0d, results %0d, mismatches %0d", items_accepted, results_checked,
             mismatches);
    $display("key interrupts %0d, dropped key updates %0d, timer4 requests %0d",
             keyrupts_seen, drops_seen, time4_seen);
    if (mismatches == 0 && awaited_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
